// ----- hdl/lfef_pkg.sv -----
// Shared widths, reset values and register codes for the LED fire effect frame generator.
`default_nettype none

package lfef_pkg;

    // Default strip length
    localparam int CELL_COUNT_DEF = 60;

    // Field widths
    localparam int HEAT_W      = 8;
    localparam int PIXEL_W     = 6;
    localparam int COLOUR_W    = 8;
    localparam int ROLL_W      = 8;
    localparam int CELL_SEL_W  = 3;
    localparam int NOISE_W     = 16;

    // Bit-serial divider widths: the noise word over a cooldown bound of up to 320
    localparam int DIVIDEND_W  = 16;
    localparam int DIVISOR_W   = 9;
    localparam int DIV_COUNT_W = $clog2(DIVIDEND_W + 1);

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COOLING_RATE = 2'd0,
        CFG_SPARK_CHANCE = 2'd1,
        CFG_NOISE_SEED   = 2'd2
    } cfg_index_t;

    // Register reset values
    localparam logic [7:0]         COOLING_RATE_RST = 8'd7;
    localparam logic [7:0]         SPARK_CHANCE_RST = 8'd20;
    localparam logic [NOISE_W-1:0] NOISE_RST        = 16'd1;

endpackage : lfef_pkg

`default_nettype wire

// ----- hdl/lfef_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lfef_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, read before write on a shared address
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule : lfef_ram

`default_nettype wire

// ----- hdl/lfef_divider.sv -----
// Restoring bit-serial divider: one quotient bit per cycle.
`default_nettype none

module lfef_divider (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [lfef_pkg::DIVIDEND_W-1:0] dividend,
    input  wire logic [lfef_pkg::DIVISOR_W-1:0]  divisor,
    output logic                                 done,
    output logic      [lfef_pkg::DIVISOR_W-1:0]  remainder
);

    import lfef_pkg::*;

    logic [DIVIDEND_W-1:0]  quo_reg;
    logic [DIVISOR_W-1:0]   rem_reg;
    logic [DIVISOR_W-1:0]   div_reg;
    logic [DIV_COUNT_W-1:0] cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [DIVISOR_W:0]     trial;
    logic                   fits;
    logic [DIVISOR_W-1:0]   rem_next;

    // Shift the next dividend bit into the partial remainder and trial-subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? DIVISOR_W'(trial - {1'b0, div_reg}) : trial[DIVISOR_W-1:0];
    end

    // Iterate one bit per cycle, flag completion for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
                cnt_reg  <= DIV_COUNT_W'(DIVIDEND_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_COUNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule : lfef_divider

`default_nettype wire

// ----- hdl/lfef_heat_store.sv -----
// Heat store: cell heat RAM with per-cell valid bits that give zero heat after reset.
`default_nettype none

module lfef_heat_store #(
    parameter int CELL_COUNT = lfef_pkg::CELL_COUNT_DEF,
    parameter int ADDR_W     = $clog2(CELL_COUNT)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        we,
    input  wire logic [ADDR_W-1:0]           waddr,
    input  wire logic [lfef_pkg::HEAT_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0]           raddr,
    output logic      [lfef_pkg::HEAT_W-1:0] rdata
);

    import lfef_pkg::*;

    logic [CELL_COUNT-1:0] valid_reg;
    logic                  rd_valid_reg;
    logic [HEAT_W-1:0]     ram_rdata;

    lfef_ram #(
        .WIDTH  (HEAT_W),
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Mark written cells; sample the valid bit alongside the RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[raddr];
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    // A cell never written since reset reads as cold
    assign rdata = rd_valid_reg ? ram_rdata : '0;

endmodule : lfef_heat_store

`default_nettype wire

// ----- hdl/led_fire_effect_frame.sv -----
// Top level of the LED fire effect frame generator: frame sequencer and colour output.
//
// One request on the input stream is one frame tick; the block then streams one
// colour per cell, cell 0 first, with tlast on the final cell. Each frame runs as a
// sequence of passes over the heat RAM: the cooldown bound is worked out once by a
// reciprocal multiply, every cell is cooled with a fresh noise word reduced by the
// bound in a 16-step bit-serial divider, the heat drifts upward for cells
// CELL_COUNT-1 down to 2, the spark is applied, and each colour is read and
// presented, the output holding each colour while the receiver stalls. The divider
// in the cooling pass dominates the frame time. The next frame request is taken
// once the last colour has been taken. The heat store reads as all cold after
// reset with no clearing pass. Configuration writes are taken at any time but are
// meant only between frames; writing a zero noise seed loads one.
`default_nettype none

module led_fire_effect_frame #(
    parameter int CELL_COUNT = lfef_pkg::CELL_COUNT_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Configuration write port
    input  wire logic                             cfg_we,
    input  wire logic [lfef_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lfef_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Frame requests
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [7:0] spark_roll, [10:8] spark_cell, [18:11] spark_heat, [23:19] zero
    input  wire logic [23:0]                      s_axis_tdata,
    // Cell colours
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [5:0] pixel_index, [13:6] red, [21:14] green, [29:22] blue, [31:30] zero
    output logic      [31:0]                      m_axis_tdata,
    // last_pixel
    output logic                                  m_axis_tlast
);

    import lfef_pkg::*;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);

    // Division by three as a reciprocal multiply, exact for sums up to 765
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int SUM_W      = HEAT_W + 2;
    localparam int PROD_W     = SUM_W + 10;

    // Cooldown bound: cooling*10 / CELL_COUNT + 2, divided by a reciprocal multiply
    localparam int COOL_SCALE   = 10;
    localparam int BOUND_MIN    = 2;
    localparam int SCALED_W     = HEAT_W + 4;
    localparam int BOUND_SHIFT  = 20;
    localparam int BOUND_MUL    = ((1 << BOUND_SHIFT) + CELL_COUNT - 1) / CELL_COUNT;
    localparam int BOUND_PROD_W = 32;

    // Colour bands
    localparam logic [7:0] BAND_HOT  = 8'h80;
    localparam logic [7:0] BAND_WARM = 8'h40;
    localparam logic [7:0] LEVEL_MUL = 8'd191;
    localparam logic [7:0] LEVEL_RND = 8'd127;
    localparam logic [COLOUR_W-1:0] FULL = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BOUND,
        ST_COOL_START,
        ST_COOL_DIV,
        ST_DRIFT_A,
        ST_DRIFT_B,
        ST_DRIFT_C,
        ST_SPARK_RD,
        ST_SPARK_WR,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_HOLD
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   idx_reg;
    logic [7:0]          cooling_reg;
    logic [7:0]          chance_reg;
    logic [NOISE_W-1:0]  noise_reg;
    logic [DIVISOR_W-1:0] bound_reg;
    logic [ROLL_W-1:0]   roll_reg;
    logic [CELL_SEL_W-1:0] cell_reg;
    logic [HEAT_W-1:0]   add_reg;
    logic [HEAT_W-1:0]   upper_reg;
    logic                out_valid_reg;
    logic                out_last_reg;
    logic [PIXEL_W-1:0]  out_idx_reg;
    logic [COLOUR_W-1:0] out_r_reg;
    logic [COLOUR_W-1:0] out_g_reg;
    logic [COLOUR_W-1:0] out_b_reg;

    logic [NOISE_W-1:0]   noise_next;
    logic                 noise_fb;
    logic                 div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic                 div_done;
    logic [DIVISOR_W-1:0] div_remainder;

    logic [SCALED_W-1:0]     cool_scaled;
    logic [BOUND_PROD_W-1:0] bound_prod;

    logic                 hs_we;
    logic [ADDR_W-1:0]    hs_waddr;
    logic [HEAT_W-1:0]    hs_wdata;
    logic [ADDR_W-1:0]    hs_raddr;
    logic [HEAT_W-1:0]    heat_rd;

    logic [HEAT_W-1:0]    cooled;
    logic [SUM_W-1:0]     drift_sum;
    logic [PROD_W-1:0]    drift_prod;
    logic [15:0]          level_x;
    logic [15:0]          level_q;
    logic [7:0]           level;
    logic [COLOUR_W-1:0]  ramp;
    logic [COLOUR_W-1:0]  col_r;
    logic [COLOUR_W-1:0]  col_g;
    logic [COLOUR_W-1:0]  col_b;

    lfef_heat_store #(
        .CELL_COUNT (CELL_COUNT),
        .ADDR_W     (ADDR_W)
    ) u_heat_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (hs_we),
        .waddr (hs_waddr),
        .wdata (hs_wdata),
        .raddr (hs_raddr),
        .rdata (heat_rd)
    );

    lfef_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_remainder)
    );

    // Noise generator: Fibonacci LFSR, taps 16,14,13,11, shifting right
    always_comb
    begin
        noise_fb   = noise_reg[0] ^ noise_reg[2] ^ noise_reg[3] ^ noise_reg[5];
        noise_next = {noise_fb, noise_reg[NOISE_W-1:1]};
    end

    // Cooldown bound numerator and its reciprocal product
    always_comb
    begin
        cool_scaled = SCALED_W'(cooling_reg) * SCALED_W'(COOL_SCALE);
        bound_prod  = BOUND_PROD_W'(cool_scaled) * BOUND_PROD_W'(BOUND_MUL);
    end

    // Cooling with a floor at zero
    always_comb
    begin
        if ({1'b0, heat_rd} < div_remainder)
        begin
            cooled = '0;
        end
        else
        begin
            cooled = HEAT_W'({1'b0, heat_rd} - div_remainder);
        end
    end

    // Drift: (upper neighbour + 2 * lower neighbour) / 3
    always_comb
    begin
        drift_sum  = SUM_W'(upper_reg) + SUM_W'({heat_rd, 1'b0});
        drift_prod = PROD_W'(drift_sum) * PROD_W'(DIV3_MUL);
    end

    // Heat to level: (h*191 + 127) / 255, with x/255 = (x + (x >> 8) + 1) >> 8
    always_comb
    begin
        level_x = 16'(heat_rd) * 16'(LEVEL_MUL) + 16'(LEVEL_RND);
        level_q = level_x + 16'(level_x[15:8]) + 16'd1;
        level   = level_q[15:8];
        ramp    = {level[5:0], 2'b00};
        if (level > BAND_HOT)
        begin
            col_r = FULL;
            col_g = FULL;
            col_b = ramp;
        end
        else if (level > BAND_WARM)
        begin
            col_r = FULL;
            col_g = ramp;
            col_b = '0;
        end
        else
        begin
            col_r = ramp;
            col_g = '0;
            col_b = '0;
        end
    end

    // Heat store and divider requests per state
    always_comb
    begin
        hs_we        = 1'b0;
        hs_waddr     = idx_reg;
        hs_wdata     = cooled;
        hs_raddr     = idx_reg;
        div_start    = 1'b0;
        div_dividend = noise_next;
        div_divisor  = bound_reg;
        case (state_reg)
            ST_COOL_START:
            begin
                div_start = 1'b1;
            end
            ST_COOL_DIV:
            begin
                hs_we = div_done;
            end
            ST_DRIFT_A:
            begin
                hs_raddr = idx_reg - 1'b1;
            end
            ST_DRIFT_B:
            begin
                hs_raddr = idx_reg - ADDR_W'(2);
            end
            ST_DRIFT_C:
            begin
                hs_raddr = idx_reg - ADDR_W'(2);
                hs_we    = 1'b1;
                hs_wdata = drift_prod[DIV3_SHIFT +: HEAT_W];
            end
            ST_SPARK_RD:
            begin
                hs_raddr = ADDR_W'(cell_reg);
            end
            ST_SPARK_WR:
            begin
                hs_raddr = ADDR_W'(cell_reg);
                hs_waddr = ADDR_W'(cell_reg);
                hs_we    = (roll_reg < chance_reg);
                hs_wdata = heat_rd + add_reg;
            end
            default:
            begin
                hs_raddr = idx_reg;
            end
        endcase
    end

    // Frame sequencer, configuration registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cooling_reg   <= COOLING_RATE_RST;
            chance_reg    <= SPARK_CHANCE_RST;
            noise_reg     <= NOISE_RST;
            bound_reg     <= '0;
            roll_reg      <= '0;
            cell_reg      <= '0;
            add_reg       <= '0;
            upper_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_idx_reg   <= '0;
            out_r_reg     <= '0;
            out_g_reg     <= '0;
            out_b_reg     <= '0;
        end
        else
        begin
            // Configuration writes; a zero seed loads one
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COOLING_RATE: cooling_reg <= cfg_data[7:0];
                    CFG_SPARK_CHANCE: chance_reg  <= cfg_data[7:0];
                    CFG_NOISE_SEED:
                    begin
                        noise_reg <= (cfg_data == '0) ? NOISE_RST : cfg_data;
                    end
                    default:
                    begin
                        cooling_reg <= cooling_reg;
                    end
                endcase
            end
            else if (state_reg == ST_COOL_START)
            begin
                noise_reg <= noise_next;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        roll_reg  <= s_axis_tdata[7:0];
                        cell_reg  <= s_axis_tdata[10:8];
                        add_reg   <= s_axis_tdata[18:11];
                        state_reg <= ST_BOUND;
                    end
                end
                ST_BOUND:
                begin
                    bound_reg <= bound_prod[BOUND_SHIFT +: DIVISOR_W] + DIVISOR_W'(BOUND_MIN);
                    idx_reg   <= '0;
                    state_reg <= ST_COOL_START;
                end
                ST_COOL_START:
                begin
                    state_reg <= ST_COOL_DIV;
                end
                ST_COOL_DIV:
                begin
                    if (div_done)
                    begin
                        if (idx_reg == LAST_CELL)
                        begin
                            state_reg <= ST_DRIFT_A;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_COOL_START;
                        end
                    end
                end
                ST_DRIFT_A:
                begin
                    state_reg <= ST_DRIFT_B;
                end
                ST_DRIFT_B:
                begin
                    upper_reg <= heat_rd;
                    state_reg <= ST_DRIFT_C;
                end
                ST_DRIFT_C:
                begin
                    if (idx_reg == ADDR_W'(2))
                    begin
                        state_reg <= ST_SPARK_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= ST_DRIFT_A;
                    end
                end
                ST_SPARK_RD:
                begin
                    state_reg <= ST_SPARK_WR;
                end
                ST_SPARK_WR:
                begin
                    idx_reg   <= '0;
                    state_reg <= ST_OUT_RD;
                end
                ST_OUT_RD:
                begin
                    state_reg <= ST_OUT_LD;
                end
                ST_OUT_LD:
                begin
                    out_valid_reg <= 1'b1;
                    out_last_reg  <= (idx_reg == LAST_CELL);
                    out_idx_reg   <= PIXEL_W'(idx_reg);
                    out_r_reg     <= col_r;
                    out_g_reg     <= col_g;
                    out_b_reg     <= col_b;
                    state_reg     <= ST_OUT_HOLD;
                end
                ST_OUT_HOLD:
                begin
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (idx_reg == LAST_CELL)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, out_b_reg, out_g_reg, out_r_reg, out_idx_reg};

endmodule : led_fire_effect_frame

`default_nettype wire

// ----- bench/led_fire_effect_frame_test.sv -----
// Self-checking testbench for the LED fire effect frame generator: frame requests in, cell colours checked.
module led_fire_effect_frame_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lfef_pkg::*;

    localparam int CELLS       = CELL_COUNT_DEF;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int TAIL_CYCLES = 2000;
    localparam int TONE_WHITE  = 'h80;
    localparam int TONE_YELLOW = 'h40;
    localparam int RAMP_MASK   = 'h3F;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [PIXEL_W-1:0]  pixel_index;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
        logic                last_pixel;
    } cell_colour_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [7:0] spark_roll, [10:8] spark_cell, [18:11] spark_heat, [23:19] zero
    logic [23:0]            s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [5:0] pixel_index, [13:6] red, [21:14] green, [29:22] blue, [31:30] zero
    logic [31:0]            m_axis_tdata;
    // last_pixel
    logic                   m_axis_tlast;

    // Predicted strip state and register copies
    logic [HEAT_W-1:0]  heat_cells [CELLS];
    logic [NOISE_W-1:0] noise_word;
    logic [7:0]         cooling_rate_q;
    logic [7:0]         spark_chance_q;
    cell_colour_t       expected_colours [$];

    int error_count;
    int cycle_count;
    int hold_cycles;
    bit calm;
    bit offering;

    led_fire_effect_frame #(
        .CELL_COUNT (CELLS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Count cycles and abandon a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("led_fire_effect_frame verification failed");
            $finish;
        end
    end

    // Drive the receiver ready: hold off on request, else idle now and then
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles--;
        end
        else if (calm)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 10);
    end

    // Record a failure
    task automatic note_failure(input string msg);
        error_count++;
        $error("%s", msg);
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
            note_failure($sformatf("%s: expected %0d, got %0d", field, want, got));
    endtask

    // Check each colour taken against the oldest prediction
    always @(posedge clk)
    begin : colour_check
        cell_colour_t got;
        cell_colour_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.pixel_index = m_axis_tdata[5:0];
            got.red         = m_axis_tdata[13:6];
            got.green       = m_axis_tdata[21:14];
            got.blue        = m_axis_tdata[29:22];
            got.last_pixel  = m_axis_tlast;
            if (expected_colours.size() == 0)
                note_failure($sformatf("colour for pixel_index %0d with no frame pending",
                                       got.pixel_index));
            else
            begin
                want = expected_colours.pop_front();
                compare_field("pixel_index", want.pixel_index, got.pixel_index);
                compare_field("red", want.red, got.red);
                compare_field("green", want.green, got.green);
                compare_field("blue", want.blue, got.blue);
                compare_field("last_pixel", want.last_pixel, got.last_pixel);
            end
        end
    end

    // Advance the strip by one frame and queue the colours it shows
    task automatic predict_frame(input logic [7:0] roll, input logic [2:0] spark_idx,
                                 input logic [7:0] add);
        int           i;
        int           bound;
        int           cooldown;
        int           tone;
        int           ramp;
        logic         fb;
        cell_colour_t c;
        bound = (int'(cooling_rate_q) * 10) / CELLS + 2;
        // Cool each cell by a fresh noise word reduced by the bound
        for (i = 0; i < CELLS; i++)
        begin
            fb = noise_word[0] ^ noise_word[2] ^ noise_word[3] ^ noise_word[5];
            noise_word = {fb, noise_word[NOISE_W-1:1]};
            cooldown = int'(noise_word) % bound;
            if (cooldown > int'(heat_cells[i]))
                heat_cells[i] = '0;
            else
                heat_cells[i] = heat_cells[i] - cooldown[HEAT_W-1:0];
        end
        // Drift heat upward, top cell first, using already updated cells
        for (i = CELLS - 1; i >= 2; i--)
            heat_cells[i] = HEAT_W'((int'(heat_cells[i-1]) + 2 * int'(heat_cells[i-2])) / 3);
        // Spark wraps modulo 256
        if (roll < spark_chance_q)
            heat_cells[spark_idx] = heat_cells[spark_idx] + add;
        // Map heat to the three colour bands
        for (i = 0; i < CELLS; i++)
        begin
            tone = (int'(heat_cells[i]) * 191 + 127) / 255;
            ramp = (tone & RAMP_MASK) << 2;
            c.pixel_index = PIXEL_W'(i);
            c.last_pixel  = (i == CELLS - 1);
            if (tone > TONE_WHITE)
            begin
                c.red   = 8'hFF;
                c.green = 8'hFF;
                c.blue  = COLOUR_W'(ramp);
            end
            else if (tone > TONE_YELLOW)
            begin
                c.red   = 8'hFF;
                c.green = COLOUR_W'(ramp);
                c.blue  = '0;
            end
            else
            begin
                c.red   = COLOUR_W'(ramp);
                c.green = '0;
                c.blue  = '0;
            end
            expected_colours.push_back(c);
        end
    endtask

    // Write one register while the block is idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_COOLING_RATE: cooling_rate_q = value[7:0];
            CFG_SPARK_CHANCE: spark_chance_q = value[7:0];
            CFG_NOISE_SEED:   noise_word = (value == '0) ? NOISE_RST : value;
            default: ;
        endcase
    endtask

    // Offer one frame request and predict it once taken
    task automatic send_frame(input logic [7:0] roll, input logic [2:0] spark_idx,
                              input logic [7:0] add);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, add, spark_idx, roll};
        offering = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_frame(roll, spark_idx, add);
        if (!calm && $urandom_range(99) < 10)
        begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    // Drop the request line and wait until every predicted colour has arrived
    task automatic settle_frames();
        if (offering)
        begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (expected_colours.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Spark heat: mostly the usual hot range, sometimes any byte
    function automatic logic [7:0] pick_heat();
        if ($urandom_range(99) < 15)
            return 8'($urandom_range(255));
        return 8'($urandom_range(254, 160));
    endfunction

    task automatic test_reset_defaults();
        send_frame(8'd0, 3'd0, 8'd255);
        send_frame(8'd19, 3'd7, 8'd160);
        send_frame(8'd20, 3'd3, 8'd200);
        send_frame(8'd255, 3'd1, 8'd254);
        send_frame(8'd0, 3'd6, 8'd0);
        send_frame(8'd1, 3'd7, 8'hFF);
        settle_frames();
    endtask

    task automatic test_register_extremes();
        // Least cooling, every roll sent here sparks: drive the heat into the white band and wrap it
        write_reg(CFG_COOLING_RATE, 16'd0);
        write_reg(CFG_SPARK_CHANCE, 16'd255);
        write_reg(CFG_NOISE_SEED, 16'hFFFF);
        send_frame(8'd254, 3'd0, 8'd254);
        send_frame(8'd0, 3'd0, 8'd128);
        send_frame(8'd0, 3'd0, 8'd100);
        send_frame(8'd0, 3'd1, 8'd200);
        send_frame(8'd254, 3'd7, 8'd254);
        send_frame(8'd100, 3'd7, 8'd170);
        settle_frames();
        // Strongest cooling, sparks never fire, zero seed loads one
        write_reg(CFG_COOLING_RATE, 16'd255);
        write_reg(CFG_SPARK_CHANCE, 16'd0);
        write_reg(CFG_NOISE_SEED, 16'd0);
        send_frame(8'd0, 3'd7, 8'd254);
        send_frame(8'd0, 3'd2, 8'd160);
        settle_frames();
        // Write to an unmapped index leaves every register alone
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        send_frame(8'd10, 3'd5, 8'd170);
        settle_frames();
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        int p;
        int n;
        for (p = 0; p < phases; p++)
        begin
            write_reg(CFG_COOLING_RATE, 16'($urandom_range(255)));
            write_reg(CFG_SPARK_CHANCE, 16'($urandom_range(255)));
            write_reg(CFG_NOISE_SEED, 16'($urandom_range(65535)));
            // One phase runs with no idling on either side
            calm = (p == 1);
            for (n = 0; n < per_phase; n++)
                send_frame(8'($urandom_range(255)), 3'($urandom_range(7)), pick_heat());
            settle_frames();
            calm = 1'b0;
        end
    endtask

    task automatic test_output_backpressure(input int frames);
        int n;
        write_reg(CFG_COOLING_RATE, 16'd40);
        write_reg(CFG_SPARK_CHANCE, 16'd200);
        write_reg(CFG_NOISE_SEED, 16'($urandom_range(65535)));
        // Hold the receiver off long past one frame while requests keep coming
        hold_cycles = 4000;
        for (n = 0; n < frames; n++)
            send_frame(8'($urandom_range(255)), 3'($urandom_range(7)), pick_heat());
        settle_frames();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        error_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        calm        = 1'b0;
        offering    = 1'b0;
        foreach (heat_cells[i])
            heat_cells[i] = '0;
        noise_word     = NOISE_RST;
        cooling_rate_q = COOLING_RATE_RST;
        spark_chance_q = SPARK_CHANCE_RST;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_phases(4, 110);
        test_output_backpressure(20);

        // Catch any colour beyond the last predicted one
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("led_fire_effect_frame verification clean");
        else
            $display("led_fire_effect_frame verification failed");
        $finish;
    end

endmodule
